### rtl/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types and constants for the stable insertion sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

    // Default number of cells in the sorting chain.
    localparam int SIS_DEPTH = 64;

    // One input item.
    typedef struct packed {
        logic signed [31:0] value;
        logic               is_last;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               end_of_set;
        logic               overflowed;
    } t_out_item;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic               valid;
        logic               greater;
        logic signed [31:0] value;
    } t_link;

    // Command broadcast to every cell in a cycle.
    typedef struct packed {
        logic               insert;
        logic               shift_out;
        logic signed [31:0] value;
    } t_ctrl;

    // Sorter phases.
    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

### rtl/sis_cell.sv
// ----------------------------------------------------------------------------
// sis_cell
// One cell of the sorting chain: holds one value and its valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_cell
    import sis_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_ctrl       i_ctrl,
    input  t_link       i_left,
    input  t_link       i_right,
    output t_link       o_link
);

    logic               r_valid;
    logic               n_valid;
    logic signed [31:0] r_value;
    logic signed [31:0] n_value;
    logic               w_greater;

    // The stored value sits after the new one when it is strictly greater.
    assign w_greater = r_valid && (r_value > i_ctrl.value);

    // Insertion shifts the greater suffix one place right; emission shifts left.
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        priority if (i_ctrl.shift_out) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end else if (i_ctrl.insert) begin
            if (i_left.greater) begin
                n_valid = i_left.valid;
                n_value = i_left.value;
            end else if ((w_greater || !r_valid) && i_left.valid) begin
                n_valid = 1'b1;
                n_value = i_ctrl.value;
            end
        end
    end

    // Valid bit is control state and is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Value register needs no reset.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.valid   = r_valid;
    assign o_link.greater = w_greater;
    assign o_link.value   = r_value;

endmodule

`default_nettype wire

### rtl/stable_insertion_sorter.sv
// ----------------------------------------------------------------------------
// stable_insertion_sorter
// Sorts a set of signed values in a chain of cells and emits it in order.
// ----------------------------------------------------------------------------
// Each accepted item is inserted into a chain of DEPTH cells, ahead of the
// first stored value strictly greater than it, so equal values keep arrival
// order; the chain accepts one item per cycle while loading.
// When an item marked last is accepted, the block stops accepting input and
// emits the set from the head cell, one result item per cycle while i_stall
// is low, shifting the chain left on each accepted result; loading resumes
// once the final result is accepted. Items that arrive while all cells are
// full are dropped, and every result of that set reports overflowed.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_insertion_sorter
    import sis_pkg::*;
#(
    parameter int DEPTH = SIS_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  t_in_item   i_data,
    output logic       o_valid,
    input  wire        i_stall,
    output t_out_item  o_data
);

    t_state     r_state;
    t_state     n_state;
    logic       r_drop;
    logic       n_drop;
    t_ctrl      w_ctrl;
    t_link      w_link [DEPTH];
    t_link      w_head;
    t_link      w_tail;
    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_full;
    logic       w_final;
    logic [DEPTH-1:0] w_vld;

    // Handshake events.
    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;
    assign w_full    = w_link[DEPTH-1].valid;
    assign w_final   = !w_link[1].valid;

    // Boundary links: the head sees a valid, smaller neighbor; the tail sees empty.
    assign w_head = '{valid: 1'b1, greater: 1'b0, value: '0};
    assign w_tail = '{valid: 1'b0, greater: 1'b0, value: '0};

    // Command to all cells.
    assign w_ctrl.insert    = w_in_acc && !w_full;
    assign w_ctrl.shift_out = w_out_acc;
    assign w_ctrl.value     = i_data.value;

    // The chain of cells.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            sis_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_left  ((gi == 0) ? w_head : w_link[(gi == 0) ? 0 : gi - 1]),
                .i_right ((gi == DEPTH - 1) ? w_tail
                                            : w_link[(gi == DEPTH - 1) ? gi : gi + 1]),
                .o_link  (w_link[gi])
            );
            assign w_vld[gi] = w_link[gi].valid;
        end
    endgenerate

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc && i_data.is_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_acc && w_final) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        o_stall = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_stall = 1'b0;
                o_valid = 1'b0;
            end
            ST_EMIT: begin
                o_stall = 1'b1;
                o_valid = 1'b1;
            end
            default: begin
                o_stall = 1'b1;
                o_valid = 1'b0;
            end
        endcase
    end

    // Sticky drop flag, cleared once the set has been emitted.
    always_comb begin
        n_drop = r_drop;
        priority if (w_out_acc && w_final) begin
            n_drop = 1'b0;
        end else if (w_in_acc && w_full) begin
            n_drop = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drop  <= n_drop;
        end
    end

    // Result item comes straight from the head cell.
    assign o_data.sorted_value = w_link[0].value;
    assign o_data.end_of_set   = w_final;
    assign o_data.overflowed   = r_drop;

    // While emitting, the head cell always holds a value.
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> w_link[0].valid)
        else $error("emitting from an empty chain");

    // Occupied cells form a contiguous run from the head.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((({1'b0, w_vld} + 1'b1) & {1'b0, w_vld}) == '0))
        else $error("gap in occupied cells");

    // Accepting the last item starts emission.
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_data.is_last) |=> (r_state == ST_EMIT))
        else $error("last item did not start emission");

    // After the final result the chain is empty and the drop flag clear.
    a_final_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && w_final) |=> (!w_link[0].valid && !r_drop))
        else $error("chain not emptied after end of set");

    // Adjacent occupied cells stay in ascending order.
    generate
        for (gi = 1; gi < DEPTH; gi++) begin : g_order
            a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                w_link[gi].valid |-> (w_link[gi - 1].value <= w_link[gi].value))
                else $error("chain out of order");
        end
    endgenerate

endmodule

`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stable insertion sorter.
// ----------------------------------------------------------------------------
// Sets of signed values are pushed through the input channel, each set
// closed by an item marked last. A tracker keeps its own sorted copy of the
// store and, on every last item, queues the ascending run of results it
// expects. Each accepted result is checked field by field against that
// queue. Directed sets cover the value extremes, duplicates, and ascending
// and descending order. Random sets are mostly short, and a few are long
// enough to fill the store and drop values. Both channels idle at random,
// except for one stretch of the run in which neither side idles.
// ----------------------------------------------------------------------------

module testbench
    import sis_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS        = SIS_DEPTH;
    localparam int TOTAL_ITEMS  = 380;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 11;

    // Tracks the sorted store and the results each set should produce.
    class sort_tracker;
        logic signed [31:0] ordered_cells[CELLS];
        int                 fill;
        bit                 dropped;
        t_out_item          pending_sorted[$];
        int                 errors;
        int                 results_checked;
        int                 sets_done;
        int                 overflow_sets;

        function new();
            fill            = 0;
            dropped         = 0;
            errors          = 0;
            results_checked = 0;
            sets_done       = 0;
            overflow_sets   = 0;
        endfunction

        // Inserts an accepted item, or drops it when the store is full.
        function void take_value(t_in_item item);
            int pos;
            t_out_item res;
            if (fill < CELLS) begin
                // Insert ahead of the first strictly greater value.
                pos = fill;
                for (int k = 0; k < fill; k++) begin
                    if (ordered_cells[k] > item.value) begin
                        pos = k;
                        break;
                    end
                end
                for (int k = fill; k > pos; k--) begin
                    ordered_cells[k] = ordered_cells[k - 1];
                end
                ordered_cells[pos] = item.value;
                fill++;
            end else begin
                dropped = 1'b1;
            end

            // The last item of a set releases the whole store in order.
            if (item.is_last) begin
                for (int k = 0; k < fill; k++) begin
                    res.sorted_value = ordered_cells[k];
                    res.end_of_set   = (k == fill - 1);
                    res.overflowed   = dropped;
                    pending_sorted.push_back(res);
                end
                sets_done++;
                if (dropped) begin
                    overflow_sets++;
                end
                fill    = 0;
                dropped = 1'b0;
            end
        endfunction

        // Compares one accepted result with the oldest expected one.
        function void check_result(t_out_item got);
            t_out_item exp_res;
            if (pending_sorted.size() == 0) begin
                $display("%0t: unexpected result, value %0d end %0b overflow %0b",
                         $time, got.sorted_value, got.end_of_set, got.overflowed);
                errors++;
                return;
            end
            exp_res = pending_sorted.pop_front();
            results_checked++;
            if (got.sorted_value !== exp_res.sorted_value) begin
                $display("%0t: sorted_value expected %0d, actual %0d",
                         $time, exp_res.sorted_value, got.sorted_value);
                errors++;
            end
            if (got.end_of_set !== exp_res.end_of_set) begin
                $display("%0t: end_of_set expected %0b, actual %0b",
                         $time, exp_res.end_of_set, got.end_of_set);
                errors++;
            end
            if (got.overflowed !== exp_res.overflowed) begin
                $display("%0t: overflowed expected %0b, actual %0b",
                         $time, exp_res.overflowed, got.overflowed);
                errors++;
            end
        endfunction

        function int pending();
            return pending_sorted.size();
        endfunction
    endclass

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    t_in_item  item_data    = '0;
    logic      result_stall = 1'b0;
    logic      sorter_stall;
    logic      result_valid;
    t_out_item result_data;

    sort_tracker        tracker;
    logic signed [31:0] set_vals[$];
    int                 items_sent = 0;
    bit                 idle_on    = 1'b1;
    int                 cycles     = 0;

    stable_insertion_sorter i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (item_valid),
        .o_stall (sorter_stall),
        .i_data  (item_data),
        .o_valid (result_valid),
        .i_stall (result_stall),
        .o_data  (result_data)
    );

    // Clock: 20 ns period.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: check accepted results and stall at random.
    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            tracker.check_result(result_data);
        end
        result_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end

    // Sends one item, with random idle cycles ahead of it.
    task automatic send_item(input t_in_item item);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= item;
        @(posedge clk);
        while (sorter_stall) begin
            @(posedge clk);
        end
        tracker.take_value(item);
        items_sent++;
        // One stretch in the middle of the run has no idling on either side.
        idle_on = !(items_sent >= 170 && items_sent < 270);
    endtask

    // Sends the values in set_vals, the final one marked last.
    task automatic send_set();
        t_in_item item;
        for (int k = 0; k < set_vals.size(); k++) begin
            item.value   = set_vals[k];
            item.is_last = (k == set_vals.size() - 1);
            send_item(item);
        end
    endtask

    // Mixes extremes, small clustered values and full-range values.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom_range(1) ? 32'sd0 : -32'sd1;
            3, 4: return $signed($urandom_range(6)) - 32'sd3;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        int set_len;
        int set_idx;
        tracker = new();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets: single extremes, mixed signs, duplicates, both orders.
        set_vals = '{32'sh7fff_ffff};
        send_set();
        set_vals = '{32'sh8000_0000};
        send_set();
        set_vals = '{32'sd5, -32'sd5, 32'sd0, 32'sh7fff_ffff, 32'sh8000_0000, -32'sd1,
                     32'sd1};
        send_set();
        set_vals = '{32'sd7, 32'sd7, -32'sd7, 32'sd7};
        send_set();
        set_vals = '{32'sd3, 32'sd2, 32'sd1, 32'sd0, -32'sd1};
        send_set();
        set_vals = '{-32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2};
        send_set();

        // Random sets: mostly short, a few filling the store or overflowing it.
        set_idx = 0;
        while (items_sent < TOTAL_ITEMS) begin
            if (set_idx == 1) begin
                set_len = CELLS;
            end else if (set_idx == 3) begin
                set_len = CELLS + 2;
            end else if ($urandom_range(99) < 6) begin
                set_len = $urandom_range(CELLS + 8, CELLS - 1);
            end else begin
                set_len = $urandom_range(12, 1);
            end
            set_vals.delete();
            repeat (set_len) set_vals.push_back(pick_value());
            send_set();
            set_idx++;
        end
        item_valid <= 1'b0;

        // Drain: wait for every expected result, then a short quiet period.
        while (tracker.pending() != 0) begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);

        $display("Sent %0d items in %0d sets, %0d of them overflowed.",
                 items_sent, tracker.sets_done, tracker.overflow_sets);
        $display("Checked %0d sorted results, %0d mismatches.",
                 tracker.results_checked, tracker.errors);
        if (tracker.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
